[hdl/vdm_pkg.sv]
package vdm_pkg;

	localparam int ElemWidth = 16;
	localparam int AccWidth = 48;
	localparam int RootWidth = 24;
	localparam int QueueDepth = 4;
	localparam int QueuePtrWidth = 2;

	typedef enum logic [1:0] {
		MODE_EUCLID = 2'd0,
		MODE_SQUARED = 2'd1,
		MODE_MANHATTAN = 2'd2,
		MODE_COSINE = 2'd3
	} mode_t;

	localparam logic [AccWidth-1:0] AccUMax = {AccWidth{1'b1}};
	localparam logic signed [AccWidth-1:0] AccSMax = {1'b0, {(AccWidth-1){1'b1}}};
	localparam logic signed [AccWidth-1:0] AccSMin = {1'b1, {(AccWidth-1){1'b0}}};
	localparam logic [AccWidth-1:0] OneQ16 = 48'd65536;

	// One finished vector pair, handed from the accumulating front to the back.
	typedef struct packed {
		mode_t mode;
		logic [AccWidth-1:0] diff_sum;
		logic signed [AccWidth-1:0] dot_sum;
		logic [AccWidth-1:0] norm_a_sum;
		logic [AccWidth-1:0] norm_b_sum;
	} job_t;

endpackage

[hdl/vdm_front.sv]
module vdm_front import vdm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mode_t mode,
	input logic in_valid,
	output logic in_stall,
	input logic signed [ElemWidth-1:0] a_element,
	input logic signed [ElemWidth-1:0] b_element,
	input logic last_element,
	output logic job_valid,
	input logic job_stall,
	output job_t job
);

	logic signed [ElemWidth-1:0] a_s1, b_s1;
	logic last_s1, valid_s1;
	mode_t mode_s1;
	logic signed [2*ElemWidth+1:0] sq_s2, ab_s2, aa_s2, bb_s2;
	logic [ElemWidth:0] ad_s2;
	logic last_s2, valid_s2;
	mode_t mode_s2;
	logic [AccWidth-1:0] diff_q, na_q, nb_q;
	logic signed [AccWidth-1:0] dot_q;
	logic pend_q;
	job_t pend_job_q;
	logic signed [ElemWidth:0] d_s1;
	logic [ElemWidth:0] ad_s1;
	logic [AccWidth:0] diff_n, na_n, nb_n;
	logic signed [AccWidth:0] dot_n;
	logic [AccWidth-1:0] diff_add;
	logic [AccWidth-1:0] diff_sat, na_sat, nb_sat;
	logic signed [AccWidth-1:0] dot_sat;
	logic advance;

	// The pipeline moves unless a finished job is waiting for a queue slot.
	assign advance = !pend_q;
	assign in_stall = pend_q;
	assign job_valid = pend_q;
	assign job = pend_job_q;

	assign d_s1 = {a_s1[ElemWidth-1], a_s1} - {b_s1[ElemWidth-1], b_s1};
	assign ad_s1 = d_s1[ElemWidth] ? (ElemWidth+1)'(0) - d_s1 : d_s1;

	// Stage one registers the item, stage two forms the products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1 <= a_element;
			b_s1 <= b_element;
			last_s1 <= last_element;
			mode_s1 <= mode;
			sq_s2 <= $signed({1'b0, ad_s1}) * $signed({1'b0, ad_s1});
			ab_s2 <= a_s1 * b_s1;
			aa_s2 <= a_s1 * a_s1;
			bb_s2 <= b_s1 * b_s1;
			ad_s2 <= ad_s1;
			last_s2 <= last_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Saturating accumulation of the selected terms.
	always_comb begin
		case (mode_s2)
			MODE_EUCLID, MODE_SQUARED: diff_add = AccWidth'(unsigned'(sq_s2));
			MODE_MANHATTAN: diff_add = AccWidth'(ad_s2);
			default: diff_add = '0;
		endcase
		diff_n = {1'b0, diff_q} + {1'b0, diff_add};
		na_n = {1'b0, na_q} + (AccWidth+1)'(unsigned'(aa_s2));
		nb_n = {1'b0, nb_q} + (AccWidth+1)'(unsigned'(bb_s2));
		dot_n = {dot_q[AccWidth-1], dot_q} + (AccWidth+1)'(ab_s2);
		diff_sat = diff_n[AccWidth] ? AccUMax : diff_n[AccWidth-1:0];
		na_sat = na_n[AccWidth] ? AccUMax : na_n[AccWidth-1:0];
		nb_sat = nb_n[AccWidth] ? AccUMax : nb_n[AccWidth-1:0];
		if (dot_n[AccWidth] != dot_n[AccWidth-1])
			dot_sat = dot_n[AccWidth] ? AccSMin : AccSMax;
		else
			dot_sat = dot_n[AccWidth-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
			na_q <= '0;
			nb_q <= '0;
			dot_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && !job_stall)
				pend_q <= 1'b0;
			if (advance && valid_s2) begin
				if (last_s2) begin
					diff_q <= '0;
					na_q <= '0;
					nb_q <= '0;
					dot_q <= '0;
					pend_q <= 1'b1;
				end else begin
					diff_q <= diff_sat;
					na_q <= na_sat;
					nb_q <= nb_sat;
					dot_q <= dot_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2 && last_s2) begin
			pend_job_q.mode <= mode_s2;
			pend_job_q.diff_sum <= diff_sat;
			pend_job_q.dot_sum <= dot_sat;
			pend_job_q.norm_a_sum <= na_sat;
			pend_job_q.norm_b_sum <= nb_sat;
		end
	end

endmodule

[hdl/vdm_queue.sv]
module vdm_queue import vdm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_stall,
	input job_t wr_job,
	output logic rd_valid,
	input logic rd_stall,
	output job_t rd_job
);

	job_t mem_q [QueueDepth];
	logic [QueuePtrWidth-1:0] wp_q, rp_q;
	logic [QueuePtrWidth:0] cnt_q;
	logic push, pop;

	assign wr_stall = (cnt_q == (QueuePtrWidth+1)'(QueueDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_job = mem_q[rp_q];
	assign push = wr_valid && !wr_stall;
	assign pop = rd_valid && !rd_stall;

	// Small job queue between accumulation and finishing.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrWidth+1)'(push) - (QueuePtrWidth+1)'(pop);
		end
	end

endmodule

[hdl/vdm_back.sv]
module vdm_back import vdm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_stall,
	input job_t job,
	output logic out_valid,
	input logic out_stall,
	output logic [AccWidth-1:0] distance
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ROOT = 7'b0000010,
		ST_MUL = 7'b0000100,
		ST_PREP = 7'b0001000,
		ST_DIV = 7'b0010000,
		ST_FIN = 7'b0100000,
		ST_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	job_t job_q;
	logic [5:0] step_q;
	// Three root units, one bit pair per cycle.
	logic [AccWidth-1:0] rem_q [3];
	logic [AccWidth-1:0] val_q [3];
	logic [RootWidth-1:0] root_q [3];
	logic [AccWidth-1:0] den_q;
	logic [AccWidth+16-1:0] num_q;
	logic [AccWidth:0] prem_q;
	logic [AccWidth-1:0] mag;
	logic [AccWidth-1:0] res_q;
	logic [AccWidth-1:0] dist_q;
	logic out_valid_q;
	logic [AccWidth+1:0] trial [3];
	logic [AccWidth+1:0] rem_sh [3];
	logic [AccWidth:0] prem_sh;
	logic [AccWidth:0] psub;
	logic neg;
	logic [AccWidth-1:0] qclamp;

	assign out_valid = out_valid_q;
	assign distance = dist_q;
	assign job_stall = (state_q != ST_IDLE);
	assign neg = job_q.dot_sum[AccWidth-1];
	assign mag = neg ? AccWidth'(0) - unsigned'(job_q.dot_sum) : unsigned'(job_q.dot_sum);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rem_sh[k] = {rem_q[k], val_q[k][AccWidth-1 -: 2]};
			trial[k] = {rem_sh[k][AccWidth+1:0]} -
				{(AccWidth+2-RootWidth-2)'(0), root_q[k], 2'b01};
		end
		prem_sh = {prem_q[AccWidth-1:0], num_q[AccWidth+16-1]};
		psub = prem_sh - {1'b0, den_q};
		qclamp = (num_q > AccWidth'(OneQ16)) ? OneQ16 : num_q[AccWidth-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (job_valid) begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: if (step_q == 6'd23) begin
					state_q <= (job_q.mode == MODE_COSINE) ? ST_MUL : ST_OUT;
				end
				ST_MUL: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: if (step_q == 6'd63) state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: if (!out_valid_q || !out_stall) begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: roots, one multiply, restoring divide, final select.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= job;
				step_q <= '0;
				val_q[0] <= job.diff_sum;
				val_q[1] <= job.norm_a_sum;
				val_q[2] <= job.norm_b_sum;
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= '0;
					root_q[k] <= '0;
				end
			end
			ST_ROOT: begin
				step_q <= step_q + 6'd1;
				for (int k = 0; k < 3; k++) begin
					val_q[k] <= {val_q[k][AccWidth-3:0], 2'b00};
					if (!trial[k][AccWidth+1]) begin
						rem_q[k] <= trial[k][AccWidth-1:0];
						root_q[k] <= {root_q[k][RootWidth-2:0], 1'b1};
					end else begin
						rem_q[k] <= rem_sh[k][AccWidth-1:0];
						root_q[k] <= {root_q[k][RootWidth-2:0], 1'b0};
					end
				end
			end
			ST_MUL: den_q <= root_q[1] * root_q[2];
			ST_PREP: begin
				num_q <= {mag, 16'd0};
				prem_q <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				step_q <= step_q + 6'd1;
				if (!psub[AccWidth]) begin
					prem_q <= psub;
					num_q <= {num_q[AccWidth+16-2:0], 1'b1};
				end else begin
					prem_q <= prem_sh;
					num_q <= {num_q[AccWidth+16-2:0], 1'b0};
				end
			end
			ST_FIN: begin
				if (job_q.norm_a_sum == '0 || job_q.norm_b_sum == '0 || den_q == '0)
					res_q <= OneQ16;
				else if (neg)
					res_q <= OneQ16 + qclamp;
				else
					res_q <= OneQ16 - qclamp;
			end
			// The output register only changes when the previous result has gone.
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					if (job_q.mode == MODE_EUCLID)
						dist_q <= AccWidth'(root_q[0]);
					else if (job_q.mode != MODE_COSINE)
						dist_q <= job_q.diff_sum;
					else
						dist_q <= res_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[hdl/vector_distance_metrics.sv]
// Result path: the last item of a pair passes the front pipeline stages, the pending job register,
// the job queue and the finishing unit (roots; in cosine mode also multiply and divide).
// Throughput: one element item per cycle while accumulating, stalled while a finished job
// waits to enter the queue; the finishing unit handles one vector pair at a time (24 root steps,
// 64 divide steps), and a four-entry job queue decouples it from accumulation.
// Reset: arst_n clears accumulators, queue and metric_mode to 0 and returns control to idle.
module vector_distance_metrics import vdm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic signed [ElemWidth-1:0] a_element,
	input logic signed [ElemWidth-1:0] b_element,
	input logic last_element,
	output logic out_valid,
	input logic out_stall,
	output logic [AccWidth-1:0] distance
);

	mode_t mode_q;
	logic fj_valid, fj_stall, bj_valid, bj_stall;
	job_t fj, bj;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {30'd0, mode_q} : 32'd0;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_EUCLID;
		else if (psel && penable && pwrite && paddr == 2'd0)
			mode_q <= mode_t'(pwdata[1:0]);
	end

	vdm_front u_front (
		.clk, .arst_n, .mode(mode_q), .in_valid, .in_stall,
		.a_element, .b_element, .last_element,
		.job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
	);

	vdm_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_job(fj),
		.rd_valid(bj_valid), .rd_stall(bj_stall), .rd_job(bj)
	);

	vdm_back u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_stall(bj_stall), .job(bj),
		.out_valid, .out_stall, .distance
	);

	// A cosine result never exceeds 2.0 in Q2.16.
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mode_q == MODE_COSINE && u_back.job_q.mode == MODE_COSINE)
		|-> distance <= 48'd131072) else $error("cosine distance out of range");

	// A job that the full queue stalls is held, not dropped.
	a_queue_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(fj_valid && fj_stall) |=> fj_valid) else $error("job lost before queue");

	// A held result does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(distance)))
		else $error("result changed while stalled");

endmodule

[tb/sv/tb_vector_distance_metrics.sv]
module tb_vector_distance_metrics;
	import vdm_pkg::*;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic signed [ElemWidth-1:0] a_element;
	logic signed [ElemWidth-1:0] b_element;
	logic last_element;
	logic out_valid;
	logic out_stall;
	logic [AccWidth-1:0] distance;

	localparam logic [1:0] ADDR_METRIC_MODE = 2'd0;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int LONG_RUN = 64;

	vector_distance_metrics uut (.*);

	// Free-running clock with a 20-unit period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Model of the block: mode register and the four accumulators.
	mode_t model_mode;
	longint unsigned model_diff;
	longint model_dot;
	longint unsigned model_norm_a;
	longint unsigned model_norm_b;

	longint unsigned pending_distances[$];
	int errors;
	bit calm;
	bit hold_request;

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned bitpos;
		r = 0;
		bitpos = 64'd1 << 48;
		while (bitpos > v)
			bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (v >= r + bitpos) begin
				v = v - (r + bitpos);
				r = (r >> 1) + bitpos;
			end else begin
				r = r >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned add_unsigned_sat(longint unsigned acc,
			longint unsigned add);
		longint unsigned r;
		r = acc + add;
		return (r > 64'(AccUMax)) ? 64'(AccUMax) : r;
	endfunction

	function automatic longint add_signed_sat(longint acc, longint add);
		longint r;
		longint smax;
		smax = (64'sd1 <<< 47) - 1;
		r = acc + add;
		if (r > smax)
			return smax;
		if (r < -smax - 1)
			return -smax - 1;
		return r;
	endfunction

	// One minus the clamped similarity, exactly one when a norm is zero.
	function automatic longint unsigned cosine_distance();
		longint unsigned ra;
		longint unsigned rb;
		longint unsigned den;
		longint unsigned mag;
		longint unsigned q;
		if (model_norm_a == 0 || model_norm_b == 0)
			return 64'd65536;
		ra = floor_root(model_norm_a);
		rb = floor_root(model_norm_b);
		den = ra * rb;
		if (den == 0)
			return 64'd65536;
		mag = (model_dot < 0) ? longint'(-model_dot) : longint'(model_dot);
		q = (mag << 16) / den;
		if (q > 64'd65536)
			q = 64'd65536;
		return (model_dot < 0) ? 64'd65536 + q : 64'd65536 - q;
	endfunction

	// Folds one accepted item into the model; returns 1 with the distance on a last item.
	function automatic bit accumulate_pair(logic signed [15:0] a, logic signed [15:0] b,
			logic last, output longint unsigned result);
		longint sa;
		longint sb;
		longint unsigned ad;
		sa = longint'(a);
		sb = longint'(b);
		ad = (sa - sb < 0) ? longint'(sb - sa) : longint'(sa - sb);
		result = 0;
		if (model_mode == MODE_EUCLID || model_mode == MODE_SQUARED)
			model_diff = add_unsigned_sat(model_diff, ad * ad);
		else if (model_mode == MODE_MANHATTAN)
			model_diff = add_unsigned_sat(model_diff, ad);
		model_dot = add_signed_sat(model_dot, sa * sb);
		model_norm_a = add_unsigned_sat(model_norm_a, longint'(sa * sa));
		model_norm_b = add_unsigned_sat(model_norm_b, longint'(sb * sb));
		if (!last)
			return 1'b0;
		case (model_mode)
			MODE_EUCLID: result = floor_root(model_diff);
			MODE_SQUARED, MODE_MANHATTAN: result = model_diff;
			default: result = cosine_distance();
		endcase
		model_diff = 0;
		model_dot = 0;
		model_norm_a = 0;
		model_norm_b = 0;
		return 1'b1;
	endfunction

	function automatic int random_gap(int short_max, int long_max);
		if (calm || $urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, short_max);
		return $urandom_range(10, long_max);
	endfunction

	// Offers one item, waits for acceptance and updates the model.
	// A typed expectation, where given, replaces the model's distance.
	task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last,
			bit typed, longint unsigned typed_dist);
		int gap;
		longint unsigned result;
		gap = random_gap(3, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		a_element <= a;
		b_element <= b;
		last_element <= last;
		do
			@(posedge clk);
		while (in_stall);
		if (accumulate_pair(a, b, last, result))
			pending_distances.push_back(typed ? typed_dist : result);
	endtask

	// Lets every expected distance drain, then the finishing unit settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_distances.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(mode_t mode);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_METRIC_MODE;
		pwdata <= 32'(mode);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		model_mode = mode;
	endtask

	// Receiver: checks each accepted distance and stalls at random.
	int stall_left;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_distances.size() == 0) begin
				$display("%0t distance with none expected: actual %0d", $time, distance);
				errors++;
			end else begin
				if (distance !== pending_distances[0][AccWidth-1:0]) begin
					$display("%0t distance mismatch: expected %0d actual %0d",
						$time, pending_distances[0], distance);
					errors++;
				end
				void'(pending_distances.pop_front());
			end
		end
		if (hold_request) begin
			hold_request <= 1'b0;
			stall_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= random_gap(4, 60);
			out_stall <= 1'b0;
		end
	end

	typedef struct {
		mode_t mode;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic last;
		bit typed;
		longint unsigned want;
	} directed_row_t;

	directed_row_t directed_rows[] = '{
		// After reset the block is in euclidean mode.
		'{MODE_EUCLID, 16'sd4096, 16'sd0, 1'b1, 1, 64'd4096},
		'{MODE_EUCLID, 16'sd32767, -16'sd32768, 1'b1, 1, 64'd65535},
		'{MODE_EUCLID, 16'sd0, 16'sd0, 1'b1, 1, 64'd0},
		'{MODE_EUCLID, -16'sd32768, 16'sd32767, 1'b0, 0, 64'd0},
		'{MODE_EUCLID, 16'sd1, 16'sd2, 1'b1, 0, 64'd0},
		'{MODE_SQUARED, 16'sd32767, -16'sd32768, 1'b1, 1, 64'd4294836225},
		'{MODE_SQUARED, -16'sd32768, -16'sd32768, 1'b1, 1, 64'd0},
		'{MODE_SQUARED, 16'sd5, -16'sd7, 1'b0, 0, 64'd0},
		'{MODE_SQUARED, 16'sd100, 16'sd3, 1'b1, 0, 64'd0},
		'{MODE_MANHATTAN, 16'sd32767, -16'sd32768, 1'b1, 1, 64'd65535},
		'{MODE_MANHATTAN, -16'sd32768, 16'sd32767, 1'b0, 0, 64'd0},
		'{MODE_MANHATTAN, -16'sd1, 16'sd0, 1'b1, 1, 64'd65536},
		// Cosine: zero norm, parallel, opposite and orthogonal vectors.
		'{MODE_COSINE, 16'sd0, 16'sd5, 1'b1, 1, 64'd65536},
		'{MODE_COSINE, 16'sd4096, 16'sd4096, 1'b1, 1, 64'd0},
		'{MODE_COSINE, 16'sd4096, -16'sd4096, 1'b1, 1, 64'd131072},
		'{MODE_COSINE, -16'sd32768, -16'sd32768, 1'b1, 1, 64'd0},
		'{MODE_COSINE, 16'sd4096, 16'sd0, 1'b0, 0, 64'd0},
		'{MODE_COSINE, 16'sd0, 16'sd4096, 1'b1, 1, 64'd65536},
		'{MODE_COSINE, 16'sd1234, -16'sd777, 1'b0, 0, 64'd0},
		'{MODE_COSINE, -16'sd3000, 16'sd2999, 1'b1, 0, 64'd0},
		// Mode changes part way through a vector.
		'{MODE_EUCLID, 16'sd1000, -16'sd1000, 1'b0, 0, 64'd0},
		'{MODE_COSINE, 16'sd50, 16'sd60, 1'b0, 0, 64'd0},
		'{MODE_MANHATTAN, 16'sd200, 16'sd100, 1'b1, 0, 64'd0}
	};

	function automatic logic signed [15:0] random_element(int style);
		if (style == 0)
			return 16'($urandom_range(0, 65535));
		if (style == 1)
			return 16'(int'($urandom_range(0, 64)) - 32);
		return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
	endfunction

	// Stimulus: reset, directed rows, random phases, then one long extreme vector.
	initial begin
		int sent;
		int phase;
		int len;
		int style;
		bit zero_b;
		bit open_end;
		logic signed [15:0] a;
		logic signed [15:0] b;
		errors = 0;
		calm = 0;
		hold_request = 0;
		stall_left = 0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_METRIC_MODE;
		pwdata = '0;
		in_valid = 1'b0;
		a_element = '0;
		b_element = '0;
		last_element = 1'b0;
		model_mode = MODE_EUCLID;
		model_diff = 0;
		model_dot = 0;
		model_norm_a = 0;
		model_norm_b = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].mode != model_mode) begin
				wait_idle();
				write_mode(directed_rows[i].mode);
			end
			send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].want);
		end

		sent = 0;
		phase = 0;
		while (sent < 1800) begin
			wait_idle();
			write_mode(mode_t'(phase % 4));
			if (phase == 3)
				hold_request = 1'b1;
			calm = (phase % 5 == 4);
			open_end = ($urandom_range(0, 3) == 0);
			repeat (15) begin
				len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
				style = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2);
				zero_b = ($urandom_range(0, 9) == 0);
				for (int k = 0; k < len; k++) begin
					a = random_element(style);
					b = zero_b ? 16'sd0 : random_element(style);
					if ($urandom_range(0, 15) == 0)
						b = a;
					send_pair(a, b, k == len - 1, 0, 0);
					sent++;
				end
			end
			// Some phases leave a vector open so it continues under the next mode.
			if (open_end) begin
				send_pair(random_element(0), random_element(0), 1'b0, 0, 0);
				sent++;
			end
			phase++;
		end

		// One long vector of extreme elements builds large accumulator sums.
		wait_idle();
		write_mode(MODE_SQUARED);
		calm = 1;
		for (int k = 0; k < LONG_RUN; k++)
			send_pair(16'sh7fff, 16'sh8000, k == LONG_RUN - 1, 0, 0);
		calm = 0;
		wait_idle();

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#40000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
